// ===== sv/b64d_pkg.sv =====
// b64d_pkg: shared types, status codes and the base64 alphabet lookup for the
// base64 stream decoder. No dependencies; used by every b64d_* module and the top.
package b64d_pkg;

  // Status codes carried by the closing word of a string
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadLength = 3'd1;
  localparam logic [2:0] StBadChar   = 3'd2;
  localparam logic [2:0] StAfterPad  = 3'd3;
  localparam logic [2:0] StManyPads  = 3'd4;
  localparam logic [2:0] StOverCap   = 3'd5;

  // Characters of interest
  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  // Alphabet offsets
  localparam logic [7:0] LowerBase = 8'd26;
  localparam logic [7:0] DigitBase = 8'd52;
  localparam logic [5:0] PlusVal   = 6'd62;
  localparam logic [5:0] SlashVal  = 6'd63;

  // Configuration register map
  localparam int unsigned AddrW       = 3;
  localparam logic        RegCapacity = 1'b0;
  localparam logic [15:0] CapReset    = 16'd1152;

  // Input word
  typedef struct packed {
    logic [7:0] symbol;
    logic       final_char;
  } in_item_t;

  // Output word
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_status;
    logic [2:0]  status;
    logic [15:0] byte_total;
    logic        run_end;
  } out_item_t;

  // Everything one input word produces: up to three bytes and an optional status
  typedef struct packed {
    logic [1:0]  n_data;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [15:0] base_total;
    logic        has_status;
    logic [2:0]  status;
  } bundle_t;

  // Returns {valid, sextet}; valid is low for anything outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] res;
    logic [7:0] tmp;
    res = 7'd0;
    tmp = 8'd0;
    case (ch) inside
      [CharUpA:CharUpZ]: begin
        tmp = ch - CharUpA;
        res = {1'b1, tmp[5:0]};
      end
      [CharLoA:CharLoZ]: begin
        tmp = ch - CharLoA + LowerBase;
        res = {1'b1, tmp[5:0]};
      end
      [CharZero:CharNine]: begin
        tmp = ch - CharZero + DigitBase;
        res = {1'b1, tmp[5:0]};
      end
      CharPlus:  res = {1'b1, PlusVal};
      CharSlash: res = {1'b1, SlashVal};
      default:   res = 7'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/b64d_core.sv =====
// b64d_core: input register, per-string decode state and the single-pass
// group decode. Depends on b64d_pkg.
module b64d_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64d_pkg::in_item_t  in_item_i,
  input  logic [15:0]         cap_i,
  output logic                bundle_valid_o,
  input  logic                bundle_ready_i,
  output b64d_pkg::bundle_t   bundle_o
);

  b64d_pkg::in_item_t in_q;
  logic               in_v_q;
  logic               adv;

  logic [17:0] sext_q, sext_d;
  logic [1:0]  pos_q, pos_d;
  logic [2:0]  pad_q, pad_d;
  logic [2:0]  err_q, err_d;
  logic [15:0] bytes_q, bytes_d;

  logic        is_pad;
  logic [6:0]  lut;
  logic [5:0]  val;
  logic [2:0]  cand;
  logic [2:0]  pad_n;
  logic [23:0] word;
  logic [1:0]  emit_cnt;
  logic [1:0]  emit;

  // Input register: a held word advances whenever the result buffer has room
  assign adv        = in_v_q && bundle_ready_i;
  assign in_ready_o = !in_v_q || bundle_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // Group decode
  always_comb begin
    is_pad = (in_q.symbol == b64d_pkg::PadChar);
    lut    = b64d_pkg::sextet_of(in_q.symbol);
    val    = 6'd0;
    cand   = b64d_pkg::StOk;
    pad_n  = pad_q;
    if (is_pad) begin
      pad_n = (pad_q != 3'd7) ? pad_q + 3'd1 : pad_q;
    end else if (pad_q != 3'd0) begin
      cand = b64d_pkg::StAfterPad;
    end else if (!lut[6]) begin
      cand = b64d_pkg::StBadChar;
    end else begin
      val = lut[5:0];
    end

    word     = {sext_q, val};
    emit_cnt = 2'd3 - pad_n[1:0];
    emit     = 2'd0;
    sext_d   = sext_q;
    pos_d    = pos_q;
    pad_d    = pad_n;
    err_d    = (err_q == b64d_pkg::StOk) ? cand : err_q;
    bytes_d  = bytes_q;

    if (pos_q != 2'd3) begin
      sext_d = {sext_q[11:0], val};
      pos_d  = pos_q + 2'd1;
    end else begin
      if (pad_n > 3'd2 && err_d == b64d_pkg::StOk) begin
        err_d = b64d_pkg::StManyPads;
      end
      if (err_d == b64d_pkg::StOk) begin
        if ({1'b0, bytes_q} + {15'd0, emit_cnt} > {1'b0, cap_i}) begin
          err_d = b64d_pkg::StOverCap;
        end else begin
          emit    = emit_cnt;
          bytes_d = bytes_q + {14'd0, emit_cnt};
        end
      end
      sext_d = 18'd0;
      pos_d  = 2'd0;
      pad_d  = 3'd0;
    end

    bundle_o.n_data     = emit;
    bundle_o.byte0      = word[23:16];
    bundle_o.byte1      = word[15:8];
    bundle_o.byte2      = word[7:0];
    bundle_o.base_total = bytes_q;
    bundle_o.has_status = in_q.final_char;
    bundle_o.status     = (pos_d != 2'd0) ? b64d_pkg::StBadLength : err_d;

    // End of string: back to a clean state for the next one
    if (in_q.final_char) begin
      sext_d  = 18'd0;
      pos_d   = 2'd0;
      pad_d   = 3'd0;
      err_d   = b64d_pkg::StOk;
      bytes_d = 16'd0;
    end
  end

  // Only words that produce something occupy the result buffer
  assign bundle_valid_o = in_v_q && ((emit != 2'd0) || in_q.final_char);

  // Decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sext_q  <= 18'd0;
      pos_q   <= 2'd0;
      pad_q   <= 3'd0;
      err_q   <= b64d_pkg::StOk;
      bytes_q <= 16'd0;
    end else if (adv) begin
      sext_q  <= sext_d;
      pos_q   <= pos_d;
      pad_q   <= pad_d;
      err_q   <= err_d;
      bytes_q <= bytes_d;
    end
  end

  // Closing word leaves the string state clear
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.final_char) |=>
      (pos_q == 2'd0 && pad_q == 3'd0 && err_q == b64d_pkg::StOk && bytes_q == 16'd0))
    else $error("decode state not cleared after final character");

  // Pads are only ever counted inside an open group
  a_pad_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_q != 3'd0) |-> (pos_q != 2'd0))
    else $error("pad count held outside a group");

endmodule

// ===== sv/b64d_serial.sv =====
// b64d_serial: small buffer of decode bundles and the serialiser that hands
// them out one result word per cycle while out_ready_i is high. Depends on b64d_pkg.
module b64d_serial #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 bundle_valid_i,
  output logic                 bundle_ready_o,
  input  b64d_pkg::bundle_t    bundle_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64d_pkg::out_item_t  out_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_pkg::bundle_t buf_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        idx_q;

  b64d_pkg::bundle_t head;
  logic              full, push, pop, fire_out, is_st, last;
  logic [2:0]        n_res;
  logic [15:0]       step;

  assign full           = (cnt_q == CntW'(Depth));
  assign bundle_ready_o = !full;
  assign push           = bundle_valid_i && !full;
  assign out_valid_o    = (cnt_q != '0);
  assign fire_out       = out_valid_o && out_ready_i;
  assign head           = buf_q[rd_ptr_q];

  // Position of the current word within the head bundle
  assign n_res = {1'b0, head.n_data} + {2'd0, head.has_status};
  assign last  = ({1'b0, idx_q} == n_res - 3'd1);
  assign is_st = head.has_status && (idx_q == head.n_data);
  assign pop   = fire_out && last;

  // Output word assembly
  always_comb begin
    step = is_st ? {14'd0, head.n_data} : ({14'd0, idx_q} + 16'd1);
    out_item_o.data_byte = 8'h00;
    if (!is_st) begin
      case (idx_q)
        2'd0:    out_item_o.data_byte = head.byte0;
        2'd1:    out_item_o.data_byte = head.byte1;
        2'd2:    out_item_o.data_byte = head.byte2;
        default: out_item_o.data_byte = 8'h00;
      endcase
    end
    out_item_o.is_status  = is_st;
    out_item_o.status     = is_st ? head.status : b64d_pkg::StOk;
    out_item_o.byte_total = head.base_total + step;
    out_item_o.run_end    = last;
  end

  // Buffer storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= bundle_i;
    end
  end

  // Pointers, fill count and word index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      idx_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
        idx_q    <= 2'd0;
      end else if (fire_out) begin
        idx_q <= idx_q + 2'd1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // A status word always closes its bundle
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_status) |-> out_item_o.run_end)
    else $error("status word not last in its bundle");

  // Word index stays inside the head bundle
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, idx_q} < n_res))
    else $error("serialiser index beyond bundle");

endmodule

// ===== sv/base64_stream_decoder.sv =====
// base64_stream_decoder: top level with the configuration port and register.
// Depends on b64d_pkg, b64d_core and b64d_serial.
//
// Decodes base64 text one character per word, one word per cycle at the input.
// A character taken is held in the input register, decoded in one pass, and its
// results (up to three bytes and, on the final character, a status word) enter
// a BufDepth-entry bundle buffer, from which the first result is offered.
// Results leave one per cycle while out_ready_i is high, so a group of four
// characters yields at most four output words (three bytes plus status), and
// the input only stalls when the bundle buffer is full. The byte limit per
// string is the out_capacity register at byte address 0 of the APB port.
module base64_stream_decoder #(
  parameter int unsigned BufDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  b64d_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output b64d_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [b64d_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [15:0]       cap_q;
  logic              cap_sel;
  logic              bundle_valid, bundle_ready;
  b64d_pkg::bundle_t bundle;

  // Configuration register
  assign pready  = 1'b1;
  assign cap_sel = (paddr[b64d_pkg::AddrW-1:2] == b64d_pkg::RegCapacity);
  assign prdata  = cap_sel ? {16'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= b64d_pkg::CapReset;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[15:0];
    end
  end

  b64d_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .cap_i          (cap_q),
    .bundle_valid_o (bundle_valid),
    .bundle_ready_i (bundle_ready),
    .bundle_o       (bundle)
  );

  b64d_serial #(
    .Depth (BufDepth)
  ) u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (bundle_valid),
    .bundle_ready_o (bundle_ready),
    .bundle_i       (bundle),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

endmodule

// ===== tb/sv/base64_stream_decoder_tb.sv =====
// base64_stream_decoder_tb: self-checking bench for the base64 stream decoder.
// Needs b64d_pkg and the decoder RTL. A clocked driver feeds characters from a
// queue, a clocked monitor checks each output word against a built-in decoder.
`timescale 1ns / 100ps

module base64_stream_decoder_tb;

  typedef logic [7:0] char_q_t[$];

  localparam logic [b64d_pkg::AddrW-1:0] CapAddr    = 3'd0;
  localparam logic [b64d_pkg::AddrW-1:0] UnusedAddr = 3'd4;
  localparam int IdlePct    = 29;
  localparam int CalmFrom   = 250;
  localparam int CalmTo     = 330;
  localparam int HoldAt     = 120;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 4000;
  localparam int PhaseChars = 48;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  b64d_pkg::in_item_t  in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  b64d_pkg::out_item_t out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [b64d_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // characters waiting to be sent, decoded words waiting to arrive
  b64d_pkg::in_item_t  pending_q[$];
  b64d_pkg::out_item_t decoded_q[$];

  int   chars_taken = 0;
  int   mismatches = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   quiet_cycles = 0;
  logic calm;

  // decoder state as the bench sees it
  logic [15:0] cap_limit = b64d_pkg::CapReset;
  logic [17:0] grp_bits = '0;
  logic [1:0]  grp_pos = '0;
  logic [2:0]  pads = '0;
  logic [2:0]  err = b64d_pkg::StOk;
  logic [15:0] nbytes = '0;

  base64_stream_decoder dut (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  assign calm = (chars_taken >= CalmFrom) && (chars_taken < CalmTo);

  // ---------------------------------------------------------------- predictor
  function automatic bit char_value(input logic [7:0] c, output logic [5:0] v);
    v = '0;
    if (c >= b64d_pkg::CharUpA && c <= b64d_pkg::CharUpZ) begin
      v = 6'(c - b64d_pkg::CharUpA);
    end else if (c >= b64d_pkg::CharLoA && c <= b64d_pkg::CharLoZ) begin
      v = 6'(c - b64d_pkg::CharLoA + b64d_pkg::LowerBase);
    end else if (c >= b64d_pkg::CharZero && c <= b64d_pkg::CharNine) begin
      v = 6'(c - b64d_pkg::CharZero + b64d_pkg::DigitBase);
    end else if (c == b64d_pkg::CharPlus) begin
      v = b64d_pkg::PlusVal;
    end else if (c == b64d_pkg::CharSlash) begin
      v = b64d_pkg::SlashVal;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void flag_error(input logic [2:0] code);
    if (err == b64d_pkg::StOk) err = code;
  endfunction

  // one character in, zero to four words out
  function automatic void decode_char(input b64d_pkg::in_item_t it);
    logic [5:0]          six;
    logic [23:0]         grp;
    int                  emit;
    int                  first_new;
    b64d_pkg::out_item_t r;
    first_new = decoded_q.size();
    six = '0;
    if (it.symbol == b64d_pkg::PadChar) begin
      if (pads < 3'd7) pads++;
    end else if (pads > 0) begin
      flag_error(b64d_pkg::StAfterPad);
    end else if (!char_value(it.symbol, six)) begin
      flag_error(b64d_pkg::StBadChar);
      six = '0;
    end

    if (grp_pos < 2'd3) begin
      grp_bits = {grp_bits[11:0], six};
      grp_pos++;
    end else begin
      grp = {grp_bits, six};
      if (pads > 3'd2) flag_error(b64d_pkg::StManyPads);
      if (err == b64d_pkg::StOk) begin
        emit = 3 - int'(pads);
        if (int'(nbytes) + emit > int'(cap_limit)) begin
          flag_error(b64d_pkg::StOverCap);
        end else begin
          for (int i = 0; i < emit; i++) begin
            nbytes++;
            r = '0;
            r.data_byte  = grp[23-8*i -: 8];
            r.byte_total = nbytes;
            decoded_q.push_back(r);
          end
        end
      end
      grp_bits = '0;
      grp_pos  = '0;
      pads     = '0;
    end

    // closing status word, then back to a fresh string
    if (it.final_char) begin
      r = '0;
      r.is_status  = 1'b1;
      r.status     = (grp_pos != 0) ? b64d_pkg::StBadLength : err;
      r.byte_total = nbytes;
      decoded_q.push_back(r);
      grp_bits = '0;
      grp_pos  = '0;
      pads     = '0;
      err      = b64d_pkg::StOk;
      nbytes   = '0;
    end

    if (decoded_q.size() > first_new) begin
      r = decoded_q.pop_back();
      r.run_end = 1'b1;
      decoded_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_char(in_item_i);
        chars_taken <= chars_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // random back-pressure plus one long hold-off to fill the decoder up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && chars_taken >= HoldAt) begin
      out_ready_i <= 1'b0;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic note_mismatch(input string what, input b64d_pkg::out_item_t want,
                               input b64d_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: exp byte=%h st=%b/%0d total=%0d end=%b",
               $realtime, what, want.data_byte, want.is_status, want.status,
               want.byte_total, want.run_end);
      $display("%0t: %s: got byte=%h st=%b/%0d total=%0d end=%b",
               $realtime, what, got.data_byte, got.is_status, got.status,
               got.byte_total, got.run_end);
    end
  endtask

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    b64d_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        note_mismatch("word with nothing expected", '0, out_item_o);
      end else begin
        want = decoded_q.pop_front();
        if (want.data_byte !== out_item_o.data_byte ||
            want.is_status !== out_item_o.is_status ||
            want.status !== out_item_o.status ||
            want.byte_total !== out_item_o.byte_total ||
            want.run_end !== out_item_o.run_end)
          note_mismatch("word mismatch", want, out_item_o);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("base64_stream_decoder_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic apb_write(input logic [b64d_pkg::AddrW-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CapAddr) cap_limit = data[15:0];
  endtask

  // wait until the decoder has nothing left in flight
  task automatic settle();
    while (pending_q.size() != 0 || in_valid_i || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_chars(input char_q_t cs);
    b64d_pkg::in_item_t it;
    for (int i = 0; i < cs.size(); i++) begin
      it.symbol     = cs[i];
      it.final_char = (i == cs.size() - 1);
      pending_q.push_back(it);
    end
  endtask

  task automatic push_text(input string s);
    char_q_t cs;
    for (int i = 0; i < s.len(); i++) cs.push_back(s[i]);
    push_chars(cs);
  endtask

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < b64d_pkg::LowerBase) return b64d_pkg::CharUpA + 8'(v);
    if (v < b64d_pkg::DigitBase) return b64d_pkg::CharLoA + 8'(v) - b64d_pkg::LowerBase;
    if (v < b64d_pkg::PlusVal) return b64d_pkg::CharZero + 8'(v) - b64d_pkg::DigitBase;
    if (v == b64d_pkg::PlusVal) return b64d_pkg::CharPlus;
    return b64d_pkg::CharSlash;
  endfunction

  function automatic char_q_t b64_encode(input char_q_t raw);
    char_q_t     cs;
    logic [23:0] w;
    int          left;
    for (int i = 0; i < raw.size(); i += 3) begin
      left = raw.size() - i;
      w = {raw[i], (left > 1) ? raw[i+1] : 8'h00, (left > 2) ? raw[i+2] : 8'h00};
      cs.push_back(b64_char(w[23:18]));
      cs.push_back(b64_char(w[17:12]));
      cs.push_back((left > 1) ? b64_char(w[11:6]) : b64d_pkg::PadChar);
      cs.push_back((left > 2) ? b64_char(w[5:0]) : b64d_pkg::PadChar);
    end
    return cs;
  endfunction

  // mostly clean encodings of random bytes, the rest damaged or plain noise
  task automatic queue_random_text(output int n);
    char_q_t raw;
    char_q_t cs;
    int      nb;
    int      kind;
    nb = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
    for (int i = 0; i < nb; i++) raw.push_back(8'($urandom_range(255)));
    cs = b64_encode(raw);
    kind = $urandom_range(99);
    if (kind < 70) begin
      // well-formed
    end else if (kind < 80) begin
      cs[$urandom_range(cs.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 86) begin
      cs.insert($urandom_range(cs.size() - 1), b64d_pkg::PadChar);
    end else if (kind < 90) begin
      void'(cs.pop_back());
    end else if (kind < 94) begin
      repeat ($urandom_range(1, 4)) cs.push_back(b64d_pkg::PadChar);
    end else begin
      cs.delete();
      repeat ($urandom_range(1, 9))
        cs.push_back(($urandom_range(3) == 0) ? b64d_pkg::PadChar :
                     8'($urandom_range(255)));
    end
    push_chars(cs);
    n = cs.size();
  endtask

  initial begin
    char_q_t     cs;
    logic [15:0] caps[7];
    int          n;
    int          got;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // a write to an unmapped address must leave the limit alone
    apb_write(UnusedAddr, $urandom);

    // directed: alphabet ends, one and two pads, pad misuse, bad chars, short
    push_text("Az0+");
    push_text("9/Z=");
    push_text("TQ==");
    push_text("T=Q=");
    push_text("====");
    cs = {8'h00, 8'hFF, b64d_pkg::CharUpA, b64d_pkg::CharLoA};
    push_chars(cs);
    push_text("TWF");

    // random phases, each under its own byte limit
    caps = '{16'd0, 16'd5, 16'hFFFF, 16'($urandom_range(6, 40)), 16'($urandom),
             16'd1, b64d_pkg::CapReset};
    foreach (caps[p]) begin
      settle();
      apb_write(CapAddr, {16'($urandom), caps[p]});
      n = 0;
      while (n < PhaseChars) begin
        queue_random_text(got);
        n += got;
      end
    end

    settle();
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("base64_stream_decoder_tb OK");
    end else begin
      $display("base64_stream_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
